[rtl/llim_pkg.sv]
// Shared constants and types for the lookahead peak limiter.
package llim_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int DELAY_DEPTH = 1024;
  localparam int ADDR_BITS   = $clog2(DELAY_DEPTH);
  localparam int PEAK_BITS   = 24;
  localparam int CEIL_BITS   = 23;
  localparam int COEFF_BITS  = 16;
  localparam int GAIN_BITS   = 17;
  localparam int QUOT_BITS   = 16;
  localparam int APB_ADDR_BITS = 4;
  localparam int APB_DATA_BITS = 32;

  localparam logic [GAIN_BITS-1:0]  UNITY_GAIN    = 17'h10000;
  localparam logic [CEIL_BITS-1:0]  CEILING_RESET = 23'd8388607;
  localparam logic [COEFF_BITS-1:0] RELEASE_RESET = 16'd65509;
  localparam logic [ADDR_BITS-1:0]  DELAY_RESET   = 10'd48;

  // register index, taken from paddr[3:2]
  localparam logic [1:0] REG_CEILING = 2'd0;
  localparam logic [1:0] REG_RELEASE = 2'd1;
  localparam logic [1:0] REG_DELAY   = 2'd2;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [PEAK_BITS-1:0]          peak_t;
  typedef logic [GAIN_BITS-1:0]          gain_t;

  typedef struct packed {
    sample_t left;
    sample_t right;
  } frame_t;

endpackage

[rtl/llim_if.sv]
// Valid/ready channel interfaces for sample input and limited output words.
interface llim_in_if;
  logic              valid;
  logic              ready;
  llim_pkg::sample_t left_in;
  llim_pkg::sample_t right_in;
  llim_pkg::peak_t   peak_level;

  modport source (output valid, output left_in, output right_in, output peak_level,
                  input ready);
  modport sink   (input valid, input left_in, input right_in, input peak_level,
                  output ready);
endinterface

interface llim_out_if;
  logic              valid;
  logic              ready;
  llim_pkg::sample_t left_out;
  llim_pkg::sample_t right_out;
  llim_pkg::gain_t   gain_now;

  modport source (output valid, output left_out, output right_out, output gain_now,
                  input ready);
  modport sink   (input valid, input left_out, input right_out, input gain_now,
                  output ready);
endinterface

[rtl/lookahead_peak_limiter.sv]
// Lookahead peak limiter: delay-line RAM, serial divider, shared multiplier.
// Each word steps through read, an optional 16-step restoring divider for ceiling/peak
//   (only when the peak is above the ceiling), two envelope multiplies, the envelope
//   update, two sample multiplies on the single multiplier, and output; no new word until idle.
// Reset (rst, synchronous): envelope to unity, write pointer and fill count to zero,
//   registers to their defaults; delay entries not yet written read as zero.
module lookahead_peak_limiter (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [llim_pkg::APB_ADDR_BITS-1:0]   paddr,
  input  logic [llim_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic [llim_pkg::APB_DATA_BITS-1:0]   prdata,
  output logic                                 pready,
  llim_in_if.sink                              samples,
  llim_out_if.source                           results
);

  import llim_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_READ = 4'd1;
  localparam logic [3:0] S_DIV  = 4'd2;
  localparam logic [3:0] S_MULA = 4'd3;
  localparam logic [3:0] S_MULB = 4'd4;
  localparam logic [3:0] S_ENV  = 4'd5;
  localparam logic [3:0] S_MULL = 4'd6;
  localparam logic [3:0] S_MULR = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  localparam int ACC_BITS  = 34;
  localparam int MULA_BITS = SAMPLE_BITS + 1;
  localparam int MULB_BITS = GAIN_BITS + 1;
  localparam int PROD_BITS = MULA_BITS + MULB_BITS;

  // configuration
  logic [CEIL_BITS-1:0]  ceiling_level;
  logic [COEFF_BITS-1:0] release_coeff;
  logic [ADDR_BITS-1:0]  delay_length;
  logic                  cfg_wr;

  // control
  logic [3:0]           state;
  logic [ADDR_BITS-1:0] wp;
  logic [ADDR_BITS:0]   fill;
  logic [3:0]           div_cnt;
  logic                 accept;
  logic                 out_free;

  // datapath
  sample_t              cur_l, cur_r, samp_l, samp_r, res_l;
  peak_t                peak_q;
  logic                 do_div, sel_cur, sel_zero;
  logic [PEAK_BITS-1:0] rem;
  logic [PEAK_BITS:0]   rem2, rem_diff;
  logic                 rem_ge;
  logic [QUOT_BITS-2:0] quot;
  gain_t                target, env, env_next;
  logic [GAIN_BITS-1:0] coeff_comp;
  logic [ACC_BITS-1:0]  acc, acc_sum;
  logic signed [MULA_BITS-1:0] mul_a;
  logic signed [MULB_BITS-1:0] mul_b;
  logic signed [PROD_BITS-1:0] prod_q;
  frame_t               rd_data;

  // APB register file
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      ceiling_level <= CEILING_RESET;
      release_coeff <= RELEASE_RESET;
      delay_length  <= DELAY_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_CEILING: ceiling_level <= pwdata[CEIL_BITS-1:0];
        REG_RELEASE: release_coeff <= pwdata[COEFF_BITS-1:0];
        REG_DELAY:   delay_length  <= pwdata[ADDR_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_CEILING: prdata = {{(APB_DATA_BITS-CEIL_BITS){1'b0}}, ceiling_level};
      REG_RELEASE: prdata = {{(APB_DATA_BITS-COEFF_BITS){1'b0}}, release_coeff};
      REG_DELAY:   prdata = {{(APB_DATA_BITS-ADDR_BITS){1'b0}}, delay_length};
      default:     prdata = '0;
    endcase
  end

  // delay line: both channels in one word per entry
  assign samples.ready = (state == S_IDLE) && !rst;
  assign accept        = samples.valid && samples.ready;

  llim_ram #(
    .WIDTH ($bits(frame_t)),
    .DEPTH (DELAY_DEPTH)
  ) u_delay (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (wp),
    .wr_data ({samples.left_in, samples.right_in}),
    .rd_en   (accept),
    .rd_addr (wp - delay_length),
    .rd_data (rd_data)
  );

  // divider step
  assign rem2     = {rem, 1'b0};
  assign rem_diff = rem2 - {1'b0, peak_q};
  assign rem_ge   = (rem2 >= {1'b0, peak_q});

  // shared multiplier operands
  assign coeff_comp = UNITY_GAIN - {1'b0, release_coeff};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_MULA: begin
        mul_a = signed'({{(MULA_BITS-GAIN_BITS){1'b0}}, env});
        mul_b = signed'({2'b00, release_coeff});
      end
      S_MULB: begin
        mul_a = signed'({{(MULA_BITS-GAIN_BITS){1'b0}}, target});
        mul_b = signed'({1'b0, coeff_comp});
      end
      S_MULL: begin
        mul_a = {samp_l[SAMPLE_BITS-1], samp_l};
        mul_b = signed'({1'b0, env});
      end
      S_MULR: begin
        mul_a = {samp_r[SAMPLE_BITS-1], samp_r};
        mul_b = signed'({1'b0, env});
      end
      default: ;
    endcase
  end

  assign acc_sum  = acc + prod_q[ACC_BITS-1:0];
  assign env_next = (target < env) ? target : acc_sum[GAIN_BITS+15:16];
  assign out_free = !results.valid || results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      wp            <= '0;
      fill          <= '0;
      env           <= UNITY_GAIN;
      results.valid <= 1'b0;
    end else begin
      if (results.valid && results.ready && state != S_OUT) begin
        results.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            wp <= wp + 1'b1;
            if (fill != (ADDR_BITS+1)'(DELAY_DEPTH)) begin
              fill <= fill + 1'b1;
            end
            state <= S_READ;
          end
        end
        S_READ:  state <= do_div ? S_DIV : S_MULA;
        S_DIV: begin
          if (div_cnt == 4'(QUOT_BITS - 1)) begin
            state <= S_MULA;
          end
        end
        S_MULA:  state <= S_MULB;
        S_MULB:  state <= S_ENV;
        S_ENV: begin
          env   <= env_next;
          state <= S_MULL;
        end
        S_MULL:  state <= S_MULR;
        S_MULR:  state <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            results.valid <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_l    <= samples.left_in;
      cur_r    <= samples.right_in;
      peak_q   <= samples.peak_level;
      do_div   <= (samples.peak_level > {1'b0, ceiling_level});
      sel_cur  <= (delay_length == '0);
      // entries older than the items seen since reset are read as zero, not from the RAM
      sel_zero <= (delay_length != '0) && ({1'b0, delay_length} > fill);
    end
    if (state == S_READ) begin
      samp_l  <= sel_cur ? cur_l : (sel_zero ? '0 : rd_data.left);
      samp_r  <= sel_cur ? cur_r : (sel_zero ? '0 : rd_data.right);
      rem     <= {1'b0, ceiling_level};
      div_cnt <= '0;
      if (!do_div) begin
        target <= UNITY_GAIN;
      end
    end
    if (state == S_DIV) begin
      rem     <= rem_ge ? rem_diff[PEAK_BITS-1:0] : rem2[PEAK_BITS-1:0];
      quot    <= {quot[QUOT_BITS-3:0], rem_ge};
      div_cnt <= div_cnt + 1'b1;
      if (div_cnt == 4'(QUOT_BITS - 1)) begin
        target <= {1'b0, quot, rem_ge};
      end
    end
    if (state == S_MULA || state == S_MULB || state == S_MULL || state == S_MULR) begin
      prod_q <= mul_a * mul_b;
    end
    if (state == S_MULB) begin
      acc <= prod_q[ACC_BITS-1:0];
    end
    if (state == S_MULR) begin
      // arithmetic shift by 16 floors toward minus infinity
      res_l <= prod_q[SAMPLE_BITS+15:16];
    end
    if (state == S_OUT && out_free) begin
      results.left_out  <= res_l;
      results.right_out <= prod_q[SAMPLE_BITS+15:16];
      results.gain_now  <= env;
    end
  end

`ifndef SYNTHESIS
  a_env_unity: assert property (@(posedge clk) disable iff (rst)
    env <= UNITY_GAIN)
    else $error("envelope above unity");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= (ADDR_BITS+1)'(DELAY_DEPTH))
    else $error("fill count beyond depth");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> rem < peak_q)
    else $error("divider remainder not below divisor");

  a_accept_read: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_READ)
    else $error("accepted word did not start a read");
`endif

endmodule

[rtl/llim_ram.sv]
// Simple dual-port RAM with one write port and a registered read port.
module llim_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
